// File: rtl/glmf_pkg.sv
// ----------------------------------------------------------------------------
// glmf_pkg
// Shared types and constants for the grid local minimum finder.
// ----------------------------------------------------------------------------
package glmf_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam int HEIGHT_W    = 4;
  localparam int ROW_OUT_W   = 7;
  localparam int COL_OUT_W   = 7;
  localparam int RISK_W      = 18;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 8'd100;

  // request commands
  localparam logic CMD_CELL  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [HEIGHT_W-1:0] cell_height;
  } in_item_t;

  typedef struct packed {
    logic                 is_low_point;
    logic [HEIGHT_W-1:0]  decided_height;
    logic [ROW_OUT_W-1:0] decided_row;
    logic [COL_OUT_W-1:0] decided_column;
    logic [RISK_W-1:0]    risk_total;
    logic                 frame_done;
  } out_item_t;

endpackage

// File: rtl/glmf_if.sv
// ----------------------------------------------------------------------------
// glmf_if
// Valid/ready stream channel carrying one payload of type item_t.
// ----------------------------------------------------------------------------
interface glmf_if #(
  parameter type item_t = glmf_pkg::in_item_t
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/glmf_cell.sv
// ----------------------------------------------------------------------------
// glmf_cell
// One stage of the line store: holds a height, loads either the new sample
// (at the insertion point) or its left neighbour's height on each shift.
// ----------------------------------------------------------------------------
module glmf_cell (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic                          ins,
  input  logic [glmf_pkg::HEIGHT_W-1:0] new_d,
  input  logic [glmf_pkg::HEIGHT_W-1:0] prev_d,
  output logic [glmf_pkg::HEIGHT_W-1:0] q
);
  import glmf_pkg::*;

  logic [HEIGHT_W-1:0] data_r;
  logic [HEIGHT_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (shift_en) begin
      data_nxt = ins ? new_d : prev_d;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;
endmodule

// File: rtl/glmf_line.sv
// ----------------------------------------------------------------------------
// glmf_line
// Middle and upper line stores as two chains of height cells. New samples
// enter the middle chain at cell DEPTH-len, so the oldest one sits in the end
// cell len-1 shifts later. The end of the middle chain feeds the upper chain
// at the same point.
// ----------------------------------------------------------------------------
module glmf_line #(
  parameter int DEPTH = glmf_pkg::MAX_WIDTH_DEF,
  parameter int LEN_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic [LEN_W-1:0]              len,
  input  logic [glmf_pkg::HEIGHT_W-1:0] new_d,
  output logic [glmf_pkg::HEIGHT_W-1:0] mid_q,
  output logic [glmf_pkg::HEIGHT_W-1:0] mid_next_q,
  output logic [glmf_pkg::HEIGHT_W-1:0] up_q
);
  import glmf_pkg::*;

  logic [HEIGHT_W-1:0] mid_cell_q [DEPTH];
  logic [HEIGHT_W-1:0] up_cell_q [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                ins;
      logic [HEIGHT_W-1:0] mid_prev;
      logic [HEIGHT_W-1:0] up_prev;

      assign ins = (len == LEN_W'(DEPTH - i));
      if (i == 0) begin : g_head
        assign mid_prev = new_d;
        assign up_prev  = mid_cell_q[DEPTH-1];
      end else begin : g_body
        assign mid_prev = mid_cell_q[i-1];
        assign up_prev  = up_cell_q[i-1];
      end

      glmf_cell u_mid (
        .clk      (clk),
        .shift_en (shift_en),
        .ins      (ins),
        .new_d    (new_d),
        .prev_d   (mid_prev),
        .q        (mid_cell_q[i])
      );

      // upper chain takes the height leaving the middle chain
      glmf_cell u_up (
        .clk      (clk),
        .shift_en (shift_en),
        .ins      (ins),
        .new_d    (mid_cell_q[DEPTH-1]),
        .prev_d   (up_prev),
        .q        (up_cell_q[i])
      );
    end
  endgenerate

  assign mid_q      = mid_cell_q[DEPTH-1];
  assign mid_next_q = mid_cell_q[DEPTH-2];
  assign up_q       = up_cell_q[DEPTH-1];
endmodule

// File: rtl/grid_local_minimum_finder.sv
// ----------------------------------------------------------------------------
// grid_local_minimum_finder
// Streams a height map in raster order, one cell per request, and reports
// for every cell whether it is a four-neighbour local minimum (ties count
// as low) together with a saturating risk sum of height plus one.
// ----------------------------------------------------------------------------
// Throughput is one request per clock while the output buffer is not full:
// the neighbour compare reads the end taps of two cell chains (eff_w cells in
// use) and the risk add sits in the same cycle, so nothing iterates. A cell
// is reported when the cell below it arrives, its result registered into the
// output buffer; the last row is drained by flush requests, one per column,
// and frame_done marks the flush of the final cell. Requests outside the
// frame (extra cells, early or surplus flushes) are taken and dropped.
// Results pass through a two-entry output buffer, so requests keep flowing
// while one result waits. A register write restarts the frame; line store
// contents are kept and need no clearing after reset. A width or height of
// 0 acts as 1, and values above MAX_WIDTH or MAX_HEIGHT act as those maxima.
// ----------------------------------------------------------------------------
module grid_local_minimum_finder #(
  parameter int MAX_WIDTH  = glmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = glmf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  glmf_if.sink                             in_chan,
  glmf_if.source                           out_chan,
  input  logic                             cfg_we,
  input  logic [glmf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [glmf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import glmf_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_DATA_W-1:0] grid_width_r, grid_width_nxt;
  logic [CFG_DATA_W-1:0] grid_height_r, grid_height_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [HW-1:0]         row_r, row_nxt;
  logic [WW-1:0]         flush_r, flush_nxt;
  logic [RISK_W-1:0]     risk_r, risk_nxt;
  logic [HEIGHT_W-1:0]   left_r, left_nxt;

  out_item_t             main_r, main_nxt;
  logic                  main_valid_r, main_valid_nxt;
  out_item_t             skid_r, skid_nxt;
  logic                  skid_valid_r, skid_valid_nxt;

  logic [WW-1:0]         eff_w;
  logic [HW-1:0]         eff_h;
  logic [31:0]           w_clamp, h_clamp;

  in_item_t              req;
  logic                  accept, is_cell, cell_ok, flush_ok, take_item, has_result;
  logic [WW-1:0]         col_ext, dec_col;
  logic [HW-1:0]         dec_row;
  logic                  up_ok, left_ok, right_ok, low, done;
  logic [HEIGHT_W-1:0]   mid_h, up_h, right_h, shift_d;
  logic [RISK_W:0]       risk_sum;
  logic [RISK_W-1:0]     risk_after;
  out_item_t             result;
  logic                  take_out;

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (grid_width_r == '0) begin
      w_clamp = 32'd1;
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = 32'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      h_clamp = 32'd1;
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      h_clamp = 32'(MAX_HEIGHT);
    end else begin
      h_clamp = 32'(grid_height_r);
    end
  end

  assign eff_w = WW'(w_clamp);
  assign eff_h = HW'(h_clamp);

  assign req        = in_chan.data;
  assign accept     = in_chan.valid && in_chan.ready;
  assign is_cell    = (req.cmd == CMD_CELL);
  assign col_ext    = WW'(col_r);
  assign cell_ok    = (row_r < eff_h) && (col_ext < eff_w);
  assign flush_ok   = (row_r >= eff_h) && (flush_r < eff_w);
  assign take_item  = accept && (is_cell ? cell_ok : flush_ok);
  assign has_result = take_item && (!is_cell || row_r != '0);

  // middle chain gives the cell under test and its right neighbour,
  // upper chain the cell above, left_r the cell to the left
  assign shift_d = is_cell ? req.cell_height : '0;

  glmf_line #(.DEPTH(MAX_WIDTH), .LEN_W(WW)) u_lines (
    .clk        (clk),
    .shift_en   (take_item),
    .len        (eff_w),
    .new_d      (shift_d),
    .mid_q      (mid_h),
    .mid_next_q (right_h),
    .up_q       (up_h)
  );

  assign dec_col  = is_cell ? col_ext : flush_r;
  assign dec_row  = is_cell ? (row_r - HW'(1)) : (eff_h - HW'(1));
  assign up_ok    = is_cell ? (row_r >= HW'(2)) : (eff_h >= HW'(2));
  assign left_ok  = (dec_col != '0);
  assign right_ok = ((dec_col + WW'(1)) < eff_w);

  assign low = !(up_ok && (up_h < mid_h))
            && !(is_cell && (req.cell_height < mid_h))
            && !(left_ok && (left_r < mid_h))
            && !(right_ok && (right_h < mid_h));

  assign done = !is_cell && ((flush_r + WW'(1)) >= eff_w);

  // saturating risk add
  assign risk_sum   = {1'b0, risk_r} + (RISK_W+1)'(mid_h) + (RISK_W+1)'(1);
  assign risk_after = risk_sum[RISK_W] ? '1 : risk_sum[RISK_W-1:0];

  always_comb begin
    result.is_low_point   = low;
    result.decided_height = mid_h;
    result.decided_row    = ROW_OUT_W'(dec_row);
    result.decided_column = COL_OUT_W'(dec_col);
    result.risk_total     = low ? risk_after : risk_r;
    result.frame_done     = done;
  end

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    flush_nxt       = flush_r;
    risk_nxt        = risk_r;
    left_nxt        = left_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_nxt  = cfg_wdata;
        REG_GRID_HEIGHT: grid_height_nxt = cfg_wdata;
        default:         grid_width_nxt  = grid_width_r;
      endcase
      col_nxt   = '0;
      row_nxt   = '0;
      flush_nxt = '0;
      risk_nxt  = '0;
    end else if (take_item) begin
      left_nxt = mid_h;
      if (has_result && low) begin
        risk_nxt = risk_after;
      end
      if (is_cell) begin
        if ((col_ext + WW'(1)) >= eff_w) begin
          col_nxt = '0;
          row_nxt = row_r + HW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end else begin
        flush_nxt = flush_r + WW'(1);
      end
    end
  end

  // two-entry output buffer
  assign take_out = main_valid_r && out_chan.ready;

  always_comb begin
    main_nxt       = main_r;
    main_valid_nxt = main_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!main_valid_r || take_out) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_nxt       = result;
        skid_valid_nxt = has_result;
      end else begin
        main_nxt       = result;
        main_valid_nxt = has_result;
      end
    end else if (has_result) begin
      skid_nxt       = result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
      col_r         <= '0;
      row_r         <= '0;
      flush_r       <= '0;
      risk_r        <= '0;
      main_valid_r  <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      flush_r       <= flush_nxt;
      risk_r        <= risk_nxt;
      main_valid_r  <= main_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign in_chan.ready  = !skid_valid_r;
  assign out_chan.valid = main_valid_r;
  assign out_chan.data  = main_r;
endmodule

// File: test/low_point_check_pkg.sv
// ----------------------------------------------------------------------------
// low_point_check_pkg
// Scoreboard for the grid local minimum finder: predicts the decision of
// each accepted request that yields one and checks the results against them in order.
// ----------------------------------------------------------------------------
package low_point_check_pkg;

  import glmf_pkg::*;

  localparam int unsigned RISK_CEILING = 262143;
  localparam int unsigned MAX_REPORTS  = 10;

  // a dimension of 0 acts as 1, anything above the maximum as the maximum
  function automatic int unsigned dim_in_use(int unsigned v, int unsigned max_dim);
    if (v == 0) return 1;
    return (v > max_dim) ? max_dim : v;
  endfunction

  class low_point_scoreboard;

    logic [HEIGHT_W-1:0]   upper_row [MAX_WIDTH_DEF];
    logic [HEIGHT_W-1:0]   middle_row [MAX_WIDTH_DEF];
    int unsigned           col_count;
    int unsigned           row_count;
    int unsigned           flush_count;
    int unsigned           risk_sum;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    out_item_t             pending_decisions [$];
    int unsigned           mismatches;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      mismatches = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col_count   = 0;
      row_count   = 0;
      flush_count = 0;
      risk_sum    = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_GRID_WIDTH:  width_reg  = value;
        REG_GRID_HEIGHT: height_reg = value;
        default: ;
      endcase
      restart_frame();
    endfunction

    // decide the cell at column c of the row held in middle_row
    function void decide(int unsigned c, int unsigned row, bit up_ok, bit down_ok,
                         logic [HEIGHT_W-1:0] below, bit last_cell);
      int unsigned         w;
      logic [HEIGHT_W-1:0] h;
      bit                  low;
      out_item_t           d;
      w   = dim_in_use(32'(width_reg), MAX_WIDTH_DEF);
      h   = middle_row[c];
      low = 1'b1;
      if (up_ok && upper_row[c] < h) low = 1'b0;
      if (down_ok && below < h) low = 1'b0;
      // upper_row[c-1] has already moved on and holds the left neighbour
      if (c > 0 && upper_row[c-1] < h) low = 1'b0;
      if (c + 1 < w && middle_row[c+1] < h) low = 1'b0;
      if (low) begin
        risk_sum = risk_sum + h + 1;
        if (risk_sum > RISK_CEILING) risk_sum = RISK_CEILING;
      end
      d.is_low_point   = low;
      d.decided_height = h;
      d.decided_row    = row[ROW_OUT_W-1:0];
      d.decided_column = c[COL_OUT_W-1:0];
      d.risk_total     = risk_sum[RISK_W-1:0];
      d.frame_done     = last_cell;
      pending_decisions = {pending_decisions, d};
    endfunction

    function void note_request(in_item_t req);
      int unsigned w;
      int unsigned ht;
      int unsigned c;
      w  = dim_in_use(32'(width_reg), MAX_WIDTH_DEF);
      ht = dim_in_use(32'(height_reg), MAX_HEIGHT_DEF);
      if (req.cmd == CMD_CELL) begin
        if (row_count >= ht || col_count >= w) return;
        c = col_count;
        if (row_count >= 1)
          decide(c, row_count - 1, row_count >= 2, 1'b1, req.cell_height, 1'b0);
        upper_row[c]  = middle_row[c];
        middle_row[c] = req.cell_height;
        col_count++;
        if (col_count >= w) begin
          col_count = 0;
          row_count++;
        end
      end else begin
        // flushes only count once every row is in, one per column
        if (row_count < ht || flush_count >= w) return;
        c = flush_count;
        decide(c, ht - 1, ht >= 2, 1'b0, '0, c + 1 >= w);
        upper_row[c] = middle_row[c];
        flush_count++;
      end
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    function void compare_field(string where, string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) report($sformatf("%s %s expected %0d actual %0d", where, name, want, got));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     where;
      if (pending_decisions.size() == 0) begin
        report($sformatf("result with none pending (row %0d column %0d)",
                         got.decided_row, got.decided_column));
        return;
      end
      want  = pending_decisions.pop_front();
      where = $sformatf("cell (%0d,%0d)", want.decided_row, want.decided_column);
      compare_field(where, "is_low_point", 32'(want.is_low_point), 32'(got.is_low_point));
      compare_field(where, "decided_height", 32'(want.decided_height),
                    32'(got.decided_height));
      compare_field(where, "decided_row", 32'(want.decided_row), 32'(got.decided_row));
      compare_field(where, "decided_column", 32'(want.decided_column),
                    32'(got.decided_column));
      compare_field(where, "risk_total", 32'(want.risk_total), 32'(got.risk_total));
      compare_field(where, "frame_done", 32'(want.frame_done), 32'(got.frame_done));
    endfunction

    function int unsigned outstanding();
      return pending_decisions.size();
    endfunction

    function int unsigned final_failures();
      if (pending_decisions.size() != 0)
        report($sformatf("%0d results never arrived", pending_decisions.size()));
      return mismatches;
    endfunction

  endclass

endpackage

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams height maps of many sizes through the grid local minimum finder,
// with directed corner cases, well-formed and broken frames and random
// stalls on both channels, and checks every decision against a predictor.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import glmf_pkg::*;
  import low_point_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ITEM_TARGET  = 1500;
  localparam int unsigned QUIET_TAIL   = 300;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_BROKEN,
    FRAME_TRUNCATED,
    FRAME_NOISE
  } frame_kind_e;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  glmf_if #(.item_t(in_item_t))  in_chan ();
  glmf_if #(.item_t(out_item_t)) out_chan ();

  grid_local_minimum_finder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  low_point_scoreboard sb;
  bit                  idling;
  int unsigned         stall_left;
  int unsigned         cycle_count;
  int unsigned         counted_items;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side back-pressure in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left--;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_local_minimum_finder verification failed");
      $finish;
    end else if (rst_n) begin
      if (in_chan.valid && in_chan.ready) sb.note_request(in_chan.data);
      if (out_chan.valid && out_chan.ready) sb.check_result(out_chan.data);
    end
  end

  // keep_we leaves the write enable high for a write that follows at once
  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                                bit keep_we);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
    if (!keep_we) cfg_we <= 1'b0;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic cmd, logic [HEIGHT_W-1:0] h);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.data.cmd         <= cmd;
    in_chan.data.cell_height <= h;
    do @(posedge clk); while (!in_chan.ready);
    counted_items++;
    @(negedge clk);
  endtask

  // also drops valid, so the last request is not taken twice
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_frame(logic [CFG_DATA_W-1:0] wv, logic [CFG_DATA_W-1:0] hv,
                           int unsigned lo, int unsigned hi, frame_kind_e kind);
    int unsigned w;
    int unsigned ht;
    int unsigned cut;
    if ($urandom_range(0, 1)) begin
      write_register(REG_GRID_WIDTH, wv, 1'b1);
      write_register(REG_GRID_HEIGHT, hv, 1'b0);
    end else begin
      write_register(REG_GRID_HEIGHT, hv, 1'b1);
      write_register(REG_GRID_WIDTH, wv, 1'b0);
    end
    w  = dim_in_use(32'(wv), MAX_WIDTH_DEF);
    ht = dim_in_use(32'(hv), MAX_HEIGHT_DEF);
    if (kind == FRAME_NOISE) begin
      repeat ($urandom_range(1, 2 * w + 4))
        send_request(1'($urandom_range(0, 1)), HEIGHT_W'($urandom_range(0, 15)));
    end else begin
      cut = (kind == FRAME_TRUNCATED) ? $urandom_range(0, w * ht - 1) : w * ht;
      for (int unsigned i = 0; i < cut; i++) begin
        // flush before the last row is in
        if (kind == FRAME_BROKEN && $urandom_range(0, 7) == 0)
          send_request(CMD_FLUSH, HEIGHT_W'($urandom_range(0, 15)));
        send_request(CMD_CELL, HEIGHT_W'($urandom_range(lo, hi)));
      end
      if (kind != FRAME_TRUNCATED) begin
        for (int unsigned i = 0; i < w; i++) begin
          if (kind == FRAME_BROKEN && $urandom_range(0, 3) == 0)
            send_request(CMD_CELL, HEIGHT_W'($urandom_range(0, 15)));
          send_request(CMD_FLUSH, HEIGHT_W'($urandom_range(0, 15)));
        end
        if (kind == FRAME_BROKEN) begin
          repeat ($urandom_range(1, 3))
            send_request(CMD_FLUSH, HEIGHT_W'($urandom_range(0, 15)));
          repeat ($urandom_range(0, 2))
            send_request(CMD_CELL, HEIGHT_W'($urandom_range(0, 15)));
        end
      end
    end
    // mid-frame restarts rely on this too: nothing pending before the next write
    wait_idle();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] wv;
    logic [CFG_DATA_W-1:0] hv;
    int unsigned           hi;
    frame_kind_e           kind;
    int unsigned           pick;

    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_GRID_WIDTH;
    cfg_wdata         = '0;
    in_chan.valid     = 1'b0;
    in_chan.data      = '0;
    out_chan.ready    = 1'b0;
    idling            = 1'b1;
    stall_left        = 0;
    cycle_count       = 0;
    counted_items     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset dimensions: a flush this early is dropped
    send_request(CMD_FLUSH, 4'd0);
    send_request(CMD_CELL, 4'd15);
    send_request(CMD_CELL, 4'd0);
    wait_idle();

    // 3x2 map with ties, heights above nine, an early flush, a stray cell
    // after the last row and a surplus flush at the end
    write_register(REG_GRID_WIDTH, 8'd3, 1'b1);
    write_register(REG_GRID_HEIGHT, 8'd2, 1'b0);
    send_request(CMD_CELL, 4'd4);
    send_request(CMD_CELL, 4'd4);
    send_request(CMD_CELL, 4'd15);
    send_request(CMD_FLUSH, 4'd9);
    send_request(CMD_CELL, 4'd9);
    send_request(CMD_CELL, 4'd0);
    send_request(CMD_CELL, 4'd12);
    send_request(CMD_CELL, 4'd6);
    send_request(CMD_FLUSH, 4'd15);
    send_request(CMD_FLUSH, 4'd0);
    send_request(CMD_FLUSH, 4'd10);
    send_request(CMD_FLUSH, 4'd5);
    wait_idle();

    // zero dimensions act as one: a single cell, then a finished frame
    write_register(REG_GRID_WIDTH, 8'd0, 1'b1);
    write_register(REG_GRID_HEIGHT, 8'd0, 1'b0);
    send_request(CMD_CELL, 4'd7);
    send_request(CMD_CELL, 4'd3);
    send_request(CMD_FLUSH, 4'd1);
    send_request(CMD_FLUSH, 4'd2);
    wait_idle();

    // oversize width clamps to the widest map, all cells equal and high
    run_frame(8'd200, 8'd3, 15, 15, FRAME_CLEAN);

    while (counted_items < ITEM_TARGET) begin
      idling = (counted_items + QUIET_TAIL < ITEM_TARGET) ? ($urandom_range(0, 3) != 0) : 1'b0;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        case ($urandom_range(0, 3))
          0:       wv = 8'd128;
          1:       wv = 8'd129;
          2:       wv = 8'd200;
          default: wv = 8'd255;
        endcase
        hv = CFG_DATA_W'($urandom_range(0, 2));
      end else if (pick == 1) begin
        case ($urandom_range(0, 3))
          0:       hv = 8'd128;
          1:       hv = 8'd129;
          2:       hv = 8'd200;
          default: hv = 8'd255;
        endcase
        wv = CFG_DATA_W'($urandom_range(0, 2));
      end else begin
        wv = CFG_DATA_W'($urandom_range(0, 12));
        hv = CFG_DATA_W'($urandom_range(0, 10));
      end
      case ($urandom_range(0, 3))
        0:       hi = 1;
        1:       hi = 3;
        2:       hi = 9;
        default: hi = 15;
      endcase
      case ($urandom_range(0, 9))
        0:       kind = FRAME_NOISE;
        1:       kind = FRAME_TRUNCATED;
        2, 3:    kind = FRAME_BROKEN;
        default: kind = FRAME_CLEAN;
      endcase
      run_frame(wv, hv, 0, hi, kind);
    end

    wait_idle();
    if (sb.final_failures() == 0) begin
      $display("grid_local_minimum_finder verification clean");
    end else begin
      $display("grid_local_minimum_finder verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/glmf_pkg.sv
rtl/glmf_if.sv
rtl/glmf_cell.sv
rtl/glmf_line.sv
rtl/grid_local_minimum_finder.sv
test/low_point_check_pkg.sv
test/testbench.sv
